// ----- rtl/cbs_pkg.sv -----
// Shared types, constants and helper functions for the cube-map bilinear sampler.
`default_nettype none

package cbs_pkg;

    // Signed direction components after the quarter turn need one extra bit.
    localparam int T_W = 17;

    // Face coordinate divider: the quotient is in 0..65536 and needs 17 bits.
    localparam int DIV_Q_W    = 17;
    localparam int DIV_R_W    = 18;
    localparam int DIV_STEPS  = 17;
    localparam int DIV_PER_ST = 3;
    localparam int DIV_ST     = 6;

    // Face width is image_width / 3, done as (w * 171) >> 9, exact for 8-bit w.
    localparam logic [7:0] FW_RECIP = 8'd171;
    localparam int         FW_SHIFT = 9;

    // Pipeline stage positions.
    localparam int ST_P0 = 0;
    localparam int ST_P1 = 1;
    localparam int ST_P2 = 2;
    localparam int ST_D0 = 3;
    localparam int ST_M1 = ST_D0 + DIV_ST;
    localparam int ST_M2 = ST_M1 + 1;
    localparam int ST_A1 = ST_M2 + 1;
    localparam int ST_A2 = ST_A1 + 1;
    localparam int ST_RD = ST_A2 + 1;
    localparam int ST_B1 = ST_RD + 1;
    localparam int NST   = ST_B1 + 1;

    typedef enum logic [2:0] {
        FACE_RIGHT  = 3'd0,
        FACE_LEFT   = 3'd1,
        FACE_BOTTOM = 3'd2,
        FACE_TOP    = 3'd3,
        FACE_FRONT  = 3'd4,
        FACE_BACK   = 3'd5,
        FACE_NONE   = 3'd6
    } t_face;

    // Per-face axis choice, flips and position of the face in the cross.
    typedef struct packed {
        logic [1:0] maj;
        logic [1:0] ua;
        logic [1:0] va;
        logic       uf;
        logic       vf;
        logic [1:0] fcol;
        logic [1:0] frow;
    } t_face_geo;

    // Control that travels with every word through the pipeline.
    typedef struct packed {
        logic        wr;
        t_face       face;
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [47:0] wdata;
    } t_ctl;

    // Partial state of the restoring divider.
    typedef struct packed {
        logic [DIV_R_W-1:0] rem;
        logic [DIV_Q_W-1:0] quo;
    } t_div;

    function automatic t_face_geo face_geo(t_face f);
        t_face_geo g;
        case (f)
            FACE_RIGHT:  g = '{2'd0, 2'd2, 2'd1, 1'b1, 1'b0, 2'd2, 2'd1};
            FACE_LEFT:   g = '{2'd0, 2'd2, 2'd1, 1'b1, 1'b1, 2'd0, 2'd1};
            FACE_BOTTOM: g = '{2'd1, 2'd0, 2'd2, 1'b0, 1'b1, 2'd1, 2'd2};
            FACE_TOP:    g = '{2'd1, 2'd0, 2'd2, 1'b1, 1'b1, 2'd1, 2'd0};
            FACE_FRONT:  g = '{2'd2, 2'd0, 2'd1, 1'b0, 1'b0, 2'd1, 2'd1};
            FACE_BACK:   g = '{2'd2, 2'd0, 2'd1, 1'b1, 1'b0, 2'd1, 2'd3};
            default:     g = '{2'd0, 2'd0, 2'd0, 1'b0, 1'b0, 2'd0, 2'd0};
        endcase
        return g;
    endfunction

    // One quotient bit; the first step compares without shifting.
    function automatic t_div div_step(t_div s, logic [DIV_Q_W-1:0] d, logic first);
        logic [DIV_R_W-1:0] r;
        t_div               o;
        r = first ? s.rem : {s.rem[DIV_R_W-2:0], 1'b0};
        if (r >= {1'b0, d}) begin
            o.rem = r - {1'b0, d};
            o.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
        end else begin
            o.rem = r;
            o.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cbs_texel_store.sv -----
// Texel memory: two copies with two registered read ports each, one shared write port.
`default_nettype none

module cbs_texel_store #(
    parameter int DEPTH = 49152,
    parameter int AW    = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [47:0]          i_wdata,
    input  wire logic [3:0][AW-1:0]   i_raddr,
    output logic      [3:0][47:0]     o_rdata
);

    logic [47:0] mem_a [DEPTH];
    logic [47:0] mem_b [DEPTH];
    logic [3:0][47:0] r_rdata;

    // Both copies take every write so each holds the whole image.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_a[i_waddr] <= i_wdata;
            mem_b[i_waddr] <= i_wdata;
        end
    end

    // Upper row of the quad from one copy, lower row from the other.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata[0] <= mem_a[i_raddr[0]];
            r_rdata[1] <= mem_a[i_raddr[1]];
            r_rdata[2] <= mem_b[i_raddr[2]];
            r_rdata[3] <= mem_b[i_raddr[3]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/cubemap_bilinear_sampler_core.sv -----
// Top level of the cube-map bilinear sampler: direction to face, divider, blend pipeline.
// One word is accepted per cycle while o_stall is low; each sample yields one result word.
// Throughput is one word per unstalled cycle, set by the 2x2 quad read from two dual-read copies.
// A stall on the output holds the whole pipeline; texel writes produce no result word.
// Synchronous active-low reset clears the valid bits and sets the image size to 192 x 256.
// The texel store is not cleared; a never-written texel reads as whatever the memory holds.
`default_nettype none

module cubemap_bilinear_sampler_core #(
    parameter int FACE_SIZE_MAX    = 64,
    parameter int WEIGHT_FRAC_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_func,
    input  wire logic [7:0]         i_texel_x,
    input  wire logic [7:0]         i_texel_y,
    input  wire logic [15:0]        i_in_red,
    input  wire logic [15:0]        i_in_green,
    input  wire logic [15:0]        i_in_blue,
    input  wire logic signed [15:0] i_dir_x,
    input  wire logic signed [15:0] i_dir_y,
    input  wire logic signed [15:0] i_dir_z,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_addr,
    input  wire logic [8:0]         i_cfg_wdata,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_out_red,
    output logic [15:0]             o_out_green,
    output logic [15:0]             o_out_blue,
    output logic [2:0]              o_face_index
);

    import cbs_pkg::*;

    localparam int DEPTH = 12 * FACE_SIZE_MAX * FACE_SIZE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int AXW   = (AW > 17) ? AW : 17;
    localparam int WF    = WEIGHT_FRAC_BITS;
    localparam int WW    = WF + 1;
    localparam int TW    = 16 + WF;
    localparam int TW1   = TW + 1;
    localparam int SW    = WW + TW + 1;
    localparam int SHW   = SW - 2 * WF;
    localparam logic [WW-1:0] W_ONE = WW'(1) << WF;

    localparam logic       CFG_WIDTH  = 1'b0;
    localparam logic       CFG_HEIGHT = 1'b1;

    // Configuration registers and the derived face size.
    logic [7:0] r_width;
    logic [8:0] r_height;
    logic [6:0] r_fw;
    logic [6:0] r_fh;
    logic [15:0] fw_prod;

    assign fw_prod = 16'(i_cfg_wdata[7:0]) * 16'(FW_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 8'd192;
            r_height <= 9'd256;
            r_fw     <= 7'd64;
            r_fh     <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH: begin
                    r_width <= i_cfg_wdata[7:0];
                    r_fw    <= 7'(fw_prod >> FW_SHIFT);
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg_wdata;
                    r_fh     <= i_cfg_wdata[8:2];
                end
                default: begin
                end
            endcase
        end
    end

    // Control word travels alongside; the face is filled in at the second stage.
    t_ctl  r_ctl [NST];
    t_face n_face;

    // The whole pipeline moves when the output register is free or being taken.
    logic adv;
    logic [NST-1:0] r_vld;
    logic r_out_vld;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[NST-2:0], i_valid};
            r_out_vld <= r_vld[ST_B1] && !r_ctl[ST_B1].wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctl[ST_P0].wr    <= !i_func;
            r_ctl[ST_P0].face  <= FACE_NONE;
            r_ctl[ST_P0].tx    <= i_texel_x;
            r_ctl[ST_P0].ty    <= i_texel_y;
            r_ctl[ST_P0].wdata <= {i_in_red, i_in_green, i_in_blue};
            r_ctl[ST_P1].wr    <= r_ctl[ST_P0].wr;
            r_ctl[ST_P1].face  <= n_face;
            r_ctl[ST_P1].tx    <= r_ctl[ST_P0].tx;
            r_ctl[ST_P1].ty    <= r_ctl[ST_P0].ty;
            r_ctl[ST_P1].wdata <= r_ctl[ST_P0].wdata;
            for (int i = ST_P2; i < NST; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    // Input register for the direction.
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;
    logic signed [15:0] r_dz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx <= i_dir_x;
            r_dy <= i_dir_y;
            r_dz <= i_dir_z;
        end
    end

    // Quarter turn about X, then pick the major axis (ties go to x, then y).
    logic signed [T_W-1:0] n_t [3];
    logic signed [T_W-1:0] r_t [3];
    logic [T_W-1:0] ax;
    logic [T_W-1:0] ay;
    logic [T_W-1:0] az;

    always_comb begin
        n_t[0] = T_W'(r_dx);
        n_t[1] = -T_W'(r_dz);
        n_t[2] = T_W'(r_dy);
        ax = n_t[0][T_W-1] ? T_W'(-n_t[0]) : T_W'(n_t[0]);
        ay = n_t[1][T_W-1] ? T_W'(-n_t[1]) : T_W'(n_t[1]);
        az = n_t[2][T_W-1] ? T_W'(-n_t[2]) : T_W'(n_t[2]);
        if (ax >= ay && ax >= az) begin
            if (n_t[0] > 0) begin
                n_face = FACE_RIGHT;
            end else if (n_t[0] < 0) begin
                n_face = FACE_LEFT;
            end else begin
                n_face = FACE_NONE;
            end
        end else if (ay >= ax && ay >= az) begin
            n_face = (n_t[1] > 0) ? FACE_BOTTOM : FACE_TOP;
        end else begin
            n_face = (n_t[2] > 0) ? FACE_FRONT : FACE_BACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t <= n_t;
        end
    end

    // Pick m, a and b for the face and form |a+m| or |m-a| and 2|m|.
    t_face_geo geo_p2;
    logic signed [T_W-1:0] sel_m;
    logic signed [T_W-1:0] sel_a;
    logic signed [T_W-1:0] sel_b;
    logic signed [T_W:0]   num_u;
    logic signed [T_W:0]   num_v;
    logic [T_W-1:0]        abs_m;
    logic [DIV_Q_W-1:0]    n_nu;
    logic [DIV_Q_W-1:0]    n_nv;
    logic [DIV_Q_W-1:0]    n_d;
    logic [DIV_Q_W-1:0]    r_nu;
    logic [DIV_Q_W-1:0]    r_nv;
    logic [DIV_Q_W-1:0]    r_d;

    function automatic logic signed [T_W-1:0] pick_t(logic [1:0] k,
                                                     logic signed [T_W-1:0] t0,
                                                     logic signed [T_W-1:0] t1,
                                                     logic signed [T_W-1:0] t2);
        logic signed [T_W-1:0] o;
        case (k)
            2'd0:    o = t0;
            2'd1:    o = t1;
            default: o = t2;
        endcase
        return o;
    endfunction

    always_comb begin
        geo_p2 = face_geo(r_ctl[ST_P1].face);
        sel_m  = pick_t(geo_p2.maj, r_t[0], r_t[1], r_t[2]);
        sel_a  = pick_t(geo_p2.ua, r_t[0], r_t[1], r_t[2]);
        sel_b  = pick_t(geo_p2.va, r_t[0], r_t[1], r_t[2]);
        num_u  = geo_p2.uf ? (T_W+1)'(sel_m) - (T_W+1)'(sel_a)
                           : (T_W+1)'(sel_a) + (T_W+1)'(sel_m);
        num_v  = geo_p2.vf ? (T_W+1)'(sel_m) - (T_W+1)'(sel_b)
                           : (T_W+1)'(sel_b) + (T_W+1)'(sel_m);
        abs_m  = sel_m[T_W-1] ? T_W'(-sel_m) : T_W'(sel_m);
        n_nu   = num_u[T_W] ? DIV_Q_W'(-num_u) : DIV_Q_W'(num_u);
        n_nv   = num_v[T_W] ? DIV_Q_W'(-num_v) : DIV_Q_W'(num_v);
        n_d    = {abs_m[DIV_Q_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nu <= n_nu;
            r_nv <= n_nv;
            r_d  <= n_d;
        end
    end

    // Restoring divider for u and v, a few quotient bits per stage.
    t_div               r_du [DIV_ST];
    t_div               r_dv [DIV_ST];
    logic [DIV_Q_W-1:0] r_dd [DIV_ST];

    for (genvar g = 0; g < DIV_ST; g++) begin : g_div
        t_div               in_u;
        t_div               in_v;
        logic [DIV_Q_W-1:0] in_d;
        t_div               s_u;
        t_div               s_v;

        if (g == 0) begin : g_first
            assign in_u = '{rem: {1'b0, r_nu}, quo: '0};
            assign in_v = '{rem: {1'b0, r_nv}, quo: '0};
            assign in_d = r_d;
        end else begin : g_next
            assign in_u = r_du[g-1];
            assign in_v = r_dv[g-1];
            assign in_d = r_dd[g-1];
        end

        always_comb begin
            s_u = in_u;
            s_v = in_v;
            for (int j = 0; j < DIV_PER_ST; j++) begin
                if (g * DIV_PER_ST + j < DIV_STEPS) begin
                    s_u = div_step(s_u, in_d, (g * DIV_PER_ST + j) == 0);
                    s_v = div_step(s_v, in_d, (g * DIV_PER_ST + j) == 0);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_du[g] <= s_u;
                r_dv[g] <= s_v;
                r_dd[g] <= in_d;
            end
        end
    end

    // Scale the face coordinates by the face size.
    logic [23:0] r_pu;
    logic [23:0] r_pv;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pu <= 24'(r_fw) * 24'(r_du[DIV_ST-1].quo);
            r_pv <= 24'(r_fh) * 24'(r_dv[DIV_ST-1].quo);
        end
    end

    // Texel indices, clamped to the face, and the column and row in the cross.
    function automatic logic [6:0] clamp_idx(logic [8:0] idx, logic [6:0] size);
        logic [6:0] o;
        if (size == 7'd0) begin
            o = 7'd0;
        end else if (idx > 9'(size - 7'd1)) begin
            o = size - 7'd1;
        end else begin
            o = idx[6:0];
        end
        return o;
    endfunction

    t_face_geo geo_m2;
    logic [7:0] cbase;
    logic [8:0] rbase;
    logic [6:0] u_lo;
    logic [6:0] u_hi;
    logic [6:0] v_lo;
    logic [6:0] v_hi;
    logic [7:0] n_col0;
    logic [7:0] n_col1;
    logic [8:0] n_row0;
    logic [8:0] n_row1;
    logic [7:0] r_col0;
    logic [7:0] r_col1;
    logic [8:0] r_row0;
    logic [8:0] r_row1;
    logic [WF-1:0] r_wu [4];
    logic [WF-1:0] r_wv [5];

    always_comb begin
        geo_m2 = face_geo(r_ctl[ST_M1].face);
        case (geo_m2.fcol)
            2'd0:    cbase = 8'd0;
            2'd1:    cbase = 8'(r_fw);
            default: cbase = {r_fw, 1'b0};
        endcase
        case (geo_m2.frow)
            2'd0:    rbase = 9'd0;
            2'd1:    rbase = 9'(r_fh);
            2'd2:    rbase = {1'b0, r_fh, 1'b0};
            default: rbase = 9'(r_fh) + {1'b0, r_fh, 1'b0};
        endcase
        u_lo = clamp_idx({1'b0, r_pu[23:16]}, r_fw);
        u_hi = clamp_idx({1'b0, r_pu[23:16]} + 9'd1, r_fw);
        v_lo = clamp_idx({1'b0, r_pv[23:16]}, r_fh);
        v_hi = clamp_idx({1'b0, r_pv[23:16]} + 9'd1, r_fh);
        if (r_ctl[ST_M1].wr) begin
            n_col0 = r_ctl[ST_M1].tx;
            n_col1 = r_ctl[ST_M1].tx;
            n_row0 = {1'b0, r_ctl[ST_M1].ty};
            n_row1 = {1'b0, r_ctl[ST_M1].ty};
        end else begin
            n_col0 = cbase + 8'(u_lo);
            n_col1 = cbase + 8'(u_hi);
            n_row0 = rbase + 9'(v_lo);
            n_row1 = rbase + 9'(v_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_col0  <= n_col0;
            r_col1  <= n_col1;
            r_row0  <= n_row0;
            r_row1  <= n_row1;
            r_wu[0] <= r_pu[15 -: WF];
            r_wv[0] <= r_pv[15 -: WF];
            for (int i = 1; i < 4; i++) begin
                r_wu[i] <= r_wu[i-1];
            end
            for (int i = 1; i < 5; i++) begin
                r_wv[i] <= r_wv[i-1];
            end
        end
    end

    // Row offsets in the linear store.
    logic [16:0] r_prod0;
    logic [16:0] r_prod1;
    logic [7:0]  r_acol0;
    logic [7:0]  r_acol1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod0 <= 17'(r_row0) * 17'(r_width);
            r_prod1 <= 17'(r_row1) * 17'(r_width);
            r_acol0 <= r_col0;
            r_acol1 <= r_col1;
        end
    end

    // Quad addresses, out-of-store flags and the write check.
    logic [AXW-1:0] n_addr [4];
    logic [3:0]     n_bey;
    logic           n_we;
    logic [AXW-1:0] r_addr [4];
    logic [3:0]     r_bey;
    logic           r_we;

    always_comb begin
        n_addr[0] = AXW'(r_acol0) + AXW'(r_prod0);
        n_addr[1] = AXW'(r_acol1) + AXW'(r_prod0);
        n_addr[2] = AXW'(r_acol0) + AXW'(r_prod1);
        n_addr[3] = AXW'(r_acol1) + AXW'(r_prod1);
        for (int i = 0; i < 4; i++) begin
            n_bey[i] = 32'(n_addr[i]) >= 32'(DEPTH);
        end
        n_we = r_ctl[ST_A1].wr && (r_ctl[ST_A1].tx < r_width)
            && ({1'b0, r_ctl[ST_A1].ty} < r_height) && !n_bey[0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_addr <= n_addr;
            r_bey  <= n_bey;
            r_we   <= n_we;
        end
    end

    // Texel store: write and quad read both happen as the word leaves this stage.
    logic                 mem_we;
    logic [3:0][AW-1:0]   mem_raddr;
    logic [3:0][47:0]     mem_rdata;
    logic [3:0]           r_rd_bey;

    assign mem_we = adv && r_vld[ST_A2] && r_we;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mem_raddr[i] = r_addr[i][AW-1:0];
        end
    end

    cbs_texel_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_we    (mem_we),
        .i_waddr (r_addr[0][AW-1:0]),
        .i_wdata (r_ctl[ST_A2].wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_bey <= r_bey;
        end
    end

    // Horizontal blend of the upper and lower pairs, per channel.
    logic [WW-1:0]  owu;
    logic [15:0]    px [4][3];
    logic [TW1-1:0] sum_top;
    logic [TW1-1:0] sum_bot;
    logic [TW-1:0]  n_top [3];
    logic [TW-1:0]  n_bot [3];
    logic [TW-1:0]  r_top [3];
    logic [TW-1:0]  r_bot [3];

    always_comb begin
        owu = W_ONE - WW'(r_wu[3]);
        for (int q = 0; q < 4; q++) begin
            for (int k = 0; k < 3; k++) begin
                px[q][k] = r_rd_bey[q] ? 16'd0 : mem_rdata[q][47 - 16*k -: 16];
            end
        end
        sum_top = '0;
        sum_bot = '0;
        for (int k = 0; k < 3; k++) begin
            sum_top  = TW1'(owu) * TW1'(px[0][k]) + TW1'(r_wu[3]) * TW1'(px[1][k]);
            sum_bot  = TW1'(owu) * TW1'(px[2][k]) + TW1'(r_wu[3]) * TW1'(px[3][k]);
            n_top[k] = sum_top[TW-1:0];
            n_bot[k] = sum_bot[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
    end

    // Vertical blend, drop the weight fraction, saturate (black for no face) and register the result.
    logic [WW-1:0]  owv;
    logic [SW-1:0]  vsum;
    logic [SHW-1:0] vshift;
    logic [15:0]    n_col [3];
    logic [15:0]    r_out_col [3];
    t_face          r_out_face;

    always_comb begin
        owv  = W_ONE - WW'(r_wv[4]);
        vsum = '0;
        vshift = '0;
        for (int k = 0; k < 3; k++) begin
            vsum   = SW'(owv) * SW'(r_top[k]) + SW'(r_wv[4]) * SW'(r_bot[k]);
            vshift = SHW'(vsum >> (2 * WF));
            if (r_ctl[ST_B1].face == FACE_NONE) begin
                n_col[k] = 16'd0;
            end else if (vshift > SHW'(16'hFFFF)) begin
                n_col[k] = 16'hFFFF;
            end else begin
                n_col[k] = vshift[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_col  <= n_col;
            r_out_face <= r_ctl[ST_B1].face;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_out_red    = r_out_col[0];
    assign o_out_green  = r_out_col[1];
    assign o_out_blue   = r_out_col[2];
    assign o_face_index = r_out_face;

    // A zero direction always comes out black.
    a_zero_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_face == FACE_NONE)
        |-> (o_out_red == 16'd0 && o_out_green == 16'd0 && o_out_blue == 16'd0))
        else $error("zero direction gave a nonzero color");

    // Only texel-write words reach the store write port.
    a_we_only_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_ctl[ST_A2].wr)
        else $error("store written by a sample word");

    // Writes never land beyond the store.
    a_we_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(r_addr[0]) < 32'(DEPTH)))
        else $error("store write beyond its depth");

    // The face coordinate never exceeds one.
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_M1-1] && !r_ctl[ST_M1-1].wr && r_ctl[ST_M1-1].face != FACE_NONE)
        |-> (r_du[DIV_ST-1].quo <= 17'h10000 && r_dv[DIV_ST-1].quo <= 17'h10000))
        else $error("face coordinate above one");

endmodule

`default_nettype wire

// ----- tb/tb_cubemap_bilinear_sampler_core.sv -----
// Self-checking testbench for the cube-map bilinear sampler core.
`timescale 1ns / 100ps

module tb_cubemap_bilinear_sampler_core;
    import cbs_pkg::*;

    localparam int STORE_WORDS = 49152;
    localparam int PIPE_LAT    = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REG_WIDTH   = 0;
    localparam int REG_HEIGHT  = 1;
    localparam bit FUNC_WRITE  = 1'b0;
    localparam bit FUNC_SAMPLE = 1'b1;

    // Per face: major axis, u axis, v axis, u flip, v flip, face column, face row.
    localparam int FACE_GEO[6][7] = '{
        '{0, 2, 1, 1, 0, 2, 1},
        '{0, 2, 1, 1, 1, 0, 1},
        '{1, 0, 2, 0, 1, 1, 2},
        '{1, 0, 2, 1, 1, 1, 0},
        '{2, 0, 1, 0, 0, 1, 1},
        '{2, 0, 1, 1, 0, 1, 3}
    };

    typedef struct {
        bit                 func;
        logic [7:0]         tx;
        logic [7:0]         ty;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } t_word;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        t_face       face;
    } t_pixel;

    typedef struct {
        t_word  w;
        bit     typed;
        t_pixel px;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_func;
    logic [7:0]         i_texel_x;
    logic [7:0]         i_texel_y;
    logic [15:0]        i_in_red;
    logic [15:0]        i_in_green;
    logic [15:0]        i_in_blue;
    logic signed [15:0] i_dir_x;
    logic signed [15:0] i_dir_y;
    logic signed [15:0] i_dir_z;
    logic               i_cfg_we;
    logic               i_cfg_addr;
    logic [8:0]         i_cfg_wdata;
    logic               o_valid;
    logic               i_stall;
    logic [15:0]        o_out_red;
    logic [15:0]        o_out_green;
    logic [15:0]        o_out_blue;
    logic [2:0]         o_face_index;

    cubemap_bilinear_sampler_core dut (.*);

    // Shadow of the texel store and of the image size.
    logic [47:0] shadow_texels [STORE_WORDS];
    bit          texel_written [STORE_WORDS];
    int unsigned img_w;
    int unsigned img_h;

    t_pixel      pending_pixels[$];
    int          error_count;
    int          cycle_count;
    bit          quiet;
    int          hold_cycles;
    int          stall_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Face coordinate with 16 fractional bits.
    function automatic longint unsigned face_coord(input int a, input int m, input int flip);
        int                num;
        longint unsigned   n;
        longint unsigned   d;
        num = flip ? m - a : a + m;
        n = (num < 0) ? longint'(-num) : longint'(num);
        d = 2 * ((m < 0) ? longint'(-m) : longint'(m));
        return (n << 16) / d;
    endfunction

    function automatic int unsigned clamp_index(input longint unsigned i, input int unsigned sz);
        if (sz == 0) return 0;
        return (i > sz - 1) ? sz - 1 : int'(i);
    endfunction

    // Works out face, texel addresses and blended color of one sample.
    function automatic void sample_pixel(input logic signed [15:0] dx, dy, dz,
                                         output t_pixel px, output int unsigned addr[4]);
        int                t[3];
        int unsigned       mag[3];
        int                f;
        int unsigned       fw, fh, c, r0, u0, u1, v0, v1, col, row;
        longint unsigned   u, v, pu, pv, wu, wv, top, bot, s, p[4];
        t = '{int'(dx), -int'(dz), int'(dy)};
        for (int k = 0; k < 3; k++) mag[k] = (t[k] < 0) ? -t[k] : t[k];
        if (mag[0] >= mag[1] && mag[0] >= mag[2])
            f = (t[0] > 0) ? 0 : ((t[0] < 0) ? 1 : 6);
        else if (mag[1] >= mag[2])
            f = (t[1] > 0) ? 2 : 3;
        else
            f = (t[2] > 0) ? 4 : 5;
        px = '{16'd0, 16'd0, 16'd0, FACE_NONE};
        addr = '{default: STORE_WORDS};
        if (f == 6) return;
        fw = img_w / 3;
        fh = img_h / 4;
        u = face_coord(t[FACE_GEO[f][1]], t[FACE_GEO[f][0]], FACE_GEO[f][3]);
        v = face_coord(t[FACE_GEO[f][2]], t[FACE_GEO[f][0]], FACE_GEO[f][4]);
        pu = fw * u;
        pv = fh * v;
        u0 = clamp_index(pu >> 16, fw);
        u1 = clamp_index((pu >> 16) + 1, fw);
        v0 = clamp_index(pv >> 16, fh);
        v1 = clamp_index((pv >> 16) + 1, fh);
        wu = (pu & 16'hFFFF) >> 4;
        wv = (pv & 16'hFFFF) >> 4;
        c  = FACE_GEO[f][5] * fw;
        r0 = FACE_GEO[f][6] * fh;
        for (int k = 0; k < 4; k++) begin
            col = c + ((k % 2) ? u1 : u0);
            row = r0 + ((k / 2) ? v1 : v0);
            addr[k] = col + row * img_w;
        end
        // Blend each channel, high channel first in the stored word.
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 4; k++)
                p[k] = (addr[k] < STORE_WORDS) ? shadow_texels[addr[k]][47 - 16 * ch -: 16] : 0;
            top = (4096 - wu) * p[0] + wu * p[1];
            bot = (4096 - wu) * p[2] + wu * p[3];
            s = ((4096 - wv) * top + wv * bot) >> 24;
            if (s > 65535) s = 65535;
            if (ch == 0) px.red = s[15:0];
            else if (ch == 1) px.green = s[15:0];
            else px.blue = s[15:0];
        end
        px.face = t_face'(f);
    endfunction

    // Offers one word, waits for it to be taken, then updates the shadow state.
    task automatic send_word(input t_word w, input bit typed = 0, input t_pixel want = '{0, 0, 0, FACE_NONE});
        int unsigned gap;
        int unsigned a;
        int unsigned addr[4];
        t_pixel      px;
        gap = quiet ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_func     <= w.func;
        i_texel_x  <= w.tx;
        i_texel_y  <= w.ty;
        i_in_red   <= w.red;
        i_in_green <= w.green;
        i_in_blue  <= w.blue;
        i_dir_x    <= w.dx;
        i_dir_y    <= w.dy;
        i_dir_z    <= w.dz;
        do @(posedge i_clk); while (o_stall);
        if (w.func == FUNC_WRITE) begin
            a = w.tx + w.ty * img_w;
            if (w.tx < img_w && w.ty < img_h && a < STORE_WORDS) begin
                shadow_texels[a] = {w.red, w.green, w.blue};
                texel_written[a] = 1'b1;
            end
        end else begin
            sample_pixel(w.dx, w.dy, w.dz, px, addr);
            pending_pixels.push_back(typed ? want : px);
        end
    endtask

    // Writes any texel the sample would read that holds no value yet, then samples.
    task automatic sample_dir(input t_word w, input bit typed = 0,
                              input t_pixel want = '{0, 0, 0, FACE_NONE});
        t_pixel      px;
        int unsigned addr[4];
        t_word       fill;
        sample_pixel(w.dx, w.dy, w.dz, px, addr);
        for (int k = 0; k < 4; k++) begin
            if (addr[k] < STORE_WORDS && !texel_written[addr[k]]) begin
                fill = '{FUNC_WRITE, 8'(addr[k] % img_w), 8'(addr[k] / img_w),
                         16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0};
                send_word(fill);
            end
        end
        send_word(w, typed, want);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
    endtask

    // Register writes only once the pipeline is empty.
    task automatic set_image(input int unsigned w, input int unsigned h);
        wait_drained();
        repeat (PIPE_LAT) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= 1'(REG_WIDTH);
        i_cfg_wdata <= 9'(w);
        @(negedge i_clk);
        i_cfg_addr  <= 1'(REG_HEIGHT);
        i_cfg_wdata <= 9'(h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        img_w = w & 8'hFF;
        img_h = h & 9'h1FF;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 16)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_words(input int n);
        t_word w;
        for (int i = 0; i < n; i++) begin
            w = '{FUNC_WRITE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), rand_comp(), rand_comp(), rand_comp()};
            if ($urandom_range(0, 3) == 0) begin
                send_word(w);
            end else begin
                w.func = FUNC_SAMPLE;
                // Ties along the axes now and then.
                if ($urandom_range(0, 9) == 0) begin
                    w.dy = w.dx;
                    w.dz = ($urandom_range(0, 1)) ? w.dx : -w.dx;
                end
                sample_dir(w);
            end
        end
    endtask

    // Result checker: compares each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report("unexpected result word", 0, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_red !== want.red) report("red", o_out_red, want.red);
                if (o_out_green !== want.green) report("green", o_out_green, want.green);
                if (o_out_blue !== want.blue) report("blue", o_out_blue, want.blue);
                if (o_face_index !== want.face) report("face", o_face_index, want.face);
            end
            stall_left = quiet ? 0 : $urandom_range(0, 15);
        end
    end

    // Receiver stall: a drawn wait per result, plus the occasional long hold.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Directed rows, then random phases over several image sizes.
    initial begin
        t_row rows[$];
        int unsigned sizes[8][2];
        error_count = 0;
        cycle_count = 0;
        quiet       = 0;
        hold_cycles = 0;
        stall_left  = 0;
        img_w = 192;
        img_h = 256;
        i_rst_n = 1'b0; i_valid = 1'b0; i_func = 1'b0; i_texel_x = '0; i_texel_y = '0;
        i_in_red = '0; i_in_green = '0; i_in_blue = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        i_cfg_we = 1'b0; i_cfg_addr = 1'b0; i_cfg_wdata = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_WRITE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_WRITE, 191, 255, 16'h0000, 16'hFFFF, 16'h1234, 0, 0, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_WRITE, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_WRITE, 192, 0, 16'hFFFF, 16'h0, 16'h0, 0, 0, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh7FFF, 0, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh8000, 0, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 16'sh7FFF, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 16'sh8000, 0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 16'sh7FFF}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 16'sh8000}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh4000, 16'sh4000, 16'sh4000}, 0,
              '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh0, 16'sh2000, -16'sh2000}, 0,
              '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh7FFF}, 0,
              '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh0001, 16'sh0, 16'sh0}, 0, '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh3000, -16'sh2FFF, 16'sh1000}, 0,
              '{0, 0, 0, FACE_NONE}},
            '{'{FUNC_SAMPLE, 0, 0, 0, 0, 0, 16'sh0, 16'sh0, 16'sh0}, 1, '{0, 0, 0, FACE_NONE}}
        };
        foreach (rows[i]) begin
            if (rows[i].w.func == FUNC_WRITE) send_word(rows[i].w);
            else sample_dir(rows[i].w, rows[i].typed, rows[i].px);
        end

        // Image sizes per phase: largest, smallest, face size zero, odd sizes, largest.
        // Texel fills ahead of samples add roughly as many words again.
        sizes = '{'{192, 256}, '{3, 4}, '{2, 3}, '{30, 40}, '{100, 37},
                  '{191, 255}, '{7, 9}, '{192, 256}};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) set_image(sizes[ph][0], sizes[ph][1]);
            quiet = (ph == 4);
            if (ph == 1) hold_cycles = 300;
            random_words(40);
            wait_drained();
            random_words(30);
        end

        wait_drained();
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
